### src/mswg_pkg.sv
// Package: shape codes, fixed-point constants and pipeline types of the waveform generator.
`timescale 1ns / 1ps
package mswg_pkg;

  localparam int unsigned PHASE_W  = 12;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned SHAPE_W  = 5;
  localparam int unsigned Q_FRAC   = 30;             // Q30 fraction bits
  localparam int unsigned MAG_W    = Q_FRAC + 1;     // holds 0 .. 1.0 inclusive
  localparam int unsigned PROD_W   = 2 * MAG_W;
  localparam int unsigned QIDX_W   = PHASE_W - 2;    // index within a quarter wave
  localparam int unsigned FS_PROD_W = MAG_W + SAMPLE_W - 1;

  localparam logic [MAG_W-1:0]    Q_ONE      = MAG_W'(1) << Q_FRAC;
  localparam logic [SAMPLE_W-1:0] FULL_SCALE = SAMPLE_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic [FS_PROD_W-1:0] ROUND_HALF = FS_PROD_W'(1) << (Q_FRAC - 1);

  // Odd Taylor series of sin(pi/2*t), Horner form in t^2
  localparam int unsigned N_HORNER = 6;
  localparam logic [MAG_W-1:0] HORNER_INIT = MAG_W'(61);
  localparam logic [MAG_W-1:0] HORNER_C [N_HORNER] = '{
    MAG_W'(3864), MAG_W'(172272), MAG_W'(5026995),
    MAG_W'(85569306), MAG_W'(693598668), MAG_W'(1686629713)
  };

  // Input stage, t^2 stage, Horner steps, final sine product, shape select,
  // square, cube, full-scale product, output register
  localparam int unsigned N_STAGE = N_HORNER + 8;

  typedef enum logic [SHAPE_W-1:0] {
    SH_SINE, SH_RECT_SINE, SH_ABS_SINE, SH_SQUARE,
    SH_RECT_SQUARE, SH_QUART_SINE, SH_SQUI_SINE, SH_SQUI_ABS_SINE,
    SH_SAW, SH_RECT_SAW, SH_ABS_SAW, SH_CUBE_SAW,
    SH_CUBE_RECT_SAW, SH_CUBE_ABS_SAW, SH_CUBE_SINE, SH_CUBE_RECT_SINE,
    SH_CUBE_ABS_SINE, SH_CUBE_QUART_SINE, SH_CUBE_SQUI_SINE, SH_CUBE_SQUI_ABS_SINE,
    SH_TRI, SH_RECT_TRI, SH_ABS_TRI, SH_QUART_TRI,
    SH_SQUI_TRI, SH_ABS_SQUI_TRI, SH_CUBE_TRI, SH_CUBE_RECT_TRI,
    SH_CUBE_ABS_TRI, SH_CUBE_QUART_TRI, SH_CUBE_SQUI_TRI, SH_ABS_CUBE_SQUI_TRI
  } shape_e;

  // Per-item sideband that rides along the sine pipeline
  typedef struct packed {
    shape_e             shape;
    logic [PHASE_W-1:0] p;     // original phase
    logic [MAG_W-1:0]   t;     // folded quarter-wave position, Q30
    logic               neg;   // second half of the (possibly doubled) period
    logic [MAG_W-1:0]   t2;    // t^2, Q30
  } side_t;

endpackage

### src/multi_shape_waveform_generator.sv
// Top level: pipelined multi-shape waveform generator, phase word in, Q1.15 sample out.
`timescale 1ns / 1ps
// Usage:
//  - cfg channel (cfg_valid_i / cfg_ready_o, shape_select_i) writes the 5-bit shape code;
//    always ready, takes effect for phase words accepted afterwards. Write only when idle.
//  - phase channel: one transaction per phase word, phase_i spans one period (4096 = 2*pi).
//  - sample channel: one transaction per phase word, signed sample_o, +-1.0 = +-32767.
//  - Pipeline: fourteen register stages (input stage, t^2, six Horner steps, sine product,
//    shape select, two cube products, full-scale product, output register).
//  - Throughput: one phase word per cycle unless the output stalls;
//    every stage holds one multiplier at most.
//  - Stall: the whole pipeline advances on one enable, set when the output register is
//    empty or being taken; phase_ready_o drops while the sample is held, so nothing is
//    lost or repeated. Bubbles travel as cleared valid bits.
//  - Reset: valid bits clear, shape code returns to sine; data registers are not reset.
module multi_shape_waveform_generator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [mswg_pkg::SHAPE_W-1:0]       shape_select_i,
  // phase in
  input  logic                               phase_valid_i,
  output logic                               phase_ready_o,
  input  logic [mswg_pkg::PHASE_W-1:0]       phase_i,
  // sample out
  output logic                               sample_valid_o,
  input  logic                               sample_ready_i,
  output logic signed [mswg_pkg::SAMPLE_W-1:0] sample_o
);
  import mswg_pkg::*;

  localparam int unsigned LAST = N_STAGE - 1;
  localparam int unsigned SEL  = N_HORNER + 3;   // stage index of the shape select
  localparam logic [PHASE_W:0] PH_N    = (PHASE_W + 1)'(1) << PHASE_W;
  localparam logic [PHASE_W:0] PH_HALF = (PHASE_W + 1)'(1) << (PHASE_W - 1);
  localparam logic [QIDX_W:0]  QUART_N = (QIDX_W + 1)'(1) << QIDX_W;
  localparam int unsigned SAW_SH = Q_FRAC + 1 - PHASE_W;

  shape_e shape_q;
  logic   adv;
  logic [N_STAGE-1:0] vld_q;

  // ---------------- configuration register ----------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q <= SH_SINE;
    end else if (cfg_valid_i) begin
      shape_q <= shape_e'(shape_select_i);
    end
  end

  // ---------------- pipeline control ----------------
  assign adv            = !vld_q[LAST] || sample_ready_i;
  assign phase_ready_o  = adv;
  assign sample_valid_o = vld_q[LAST];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[N_STAGE-2:0], phase_valid_i};
    end
  end

  // ---------------- stage 0: fold phase into a quarter wave ----------------
  logic               squish;
  logic [PHASE_W-1:0] pp;
  logic [QIDX_W:0]    jfold;
  side_t              side_d;
  side_t              side_q [SEL];

  always_comb begin
    case (shape_q) inside
      SH_SQUI_SINE, SH_SQUI_ABS_SINE, SH_CUBE_SQUI_SINE, SH_CUBE_SQUI_ABS_SINE,
      SH_SQUI_TRI, SH_ABS_SQUI_TRI, SH_CUBE_SQUI_TRI, SH_ABS_CUBE_SQUI_TRI: squish = 1'b1;
      default: squish = 1'b0;
    endcase
  end

  always_comb begin
    // squished shapes run at double rate in the first half period
    pp     = squish ? {phase_i[PHASE_W-2:0], 1'b0} : phase_i;
    // odd quarters mirror: position counts down from the quarter end
    jfold  = pp[PHASE_W-2] ? (QUART_N - {1'b0, pp[QIDX_W-1:0]}) : {1'b0, pp[QIDX_W-1:0]};
    side_d.shape = shape_q;
    side_d.p     = phase_i;
    side_d.t     = MAG_W'(jfold) << (Q_FRAC - QIDX_W);
    side_d.neg   = pp[PHASE_W-1];
    side_d.t2    = '0;
  end

  // ---------------- stage 1: t^2 ----------------
  logic [PROD_W-1:0] t2_prod;
  side_t             side1_d;

  assign t2_prod = PROD_W'(side_q[0].t) * PROD_W'(side_q[0].t);

  always_comb begin
    side1_d    = side_q[0];
    side1_d.t2 = t2_prod[Q_FRAC+MAG_W-1:Q_FRAC];
  end

  // sideband shift register, one entry per stage up to the shape select
  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_d;
      side_q[1] <= side1_d;
      for (int s = 2; s < int'(SEL); s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  // ---------------- stages 2..7: Horner steps r = C - r*t^2 ----------------
  logic [MAG_W-1:0]  hr_q [N_HORNER];
  logic [PROD_W-1:0] hp   [N_HORNER];

  always_comb begin
    hp[0] = PROD_W'(HORNER_INIT) * PROD_W'(side_q[1].t2);
    for (int i = 1; i < int'(N_HORNER); i++) begin
      hp[i] = PROD_W'(hr_q[i-1]) * PROD_W'(side_q[i+1].t2);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < int'(N_HORNER); i++) begin
        hr_q[i] <= HORNER_C[i] - hp[i][Q_FRAC+MAG_W-1:Q_FRAC];
      end
    end
  end

  // ---------------- stage 8: sine magnitude = t * r, clamped ----------------
  logic [PROD_W-1:0] sp;
  logic [MAG_W-1:0]  smag_d, smag_q;

  assign sp = PROD_W'(side_q[N_HORNER+1].t) * PROD_W'(hr_q[N_HORNER-1]);

  always_comb begin
    if (sp[PROD_W-1:Q_FRAC] > (PROD_W - Q_FRAC)'(Q_ONE)) begin
      smag_d = Q_ONE;
    end else begin
      smag_d = sp[Q_FRAC+MAG_W-1:Q_FRAC];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      smag_q <= smag_d;
    end
  end

  // ---------------- stage 9: shape select as sign / magnitude ----------------
  side_t            sd;
  logic             zero_h, gate, p_le_half;
  logic             s_sgn, t_sgn, w_sgn, sel_sgn, cube_d;
  logic [MAG_W-1:0] s_mag, t_mag, w_mag, aw_mag, sel_mag;
  logic             sgn_q, cube_q;
  logic [MAG_W-1:0] mag_q;

  always_comb begin
    sd        = side_q[SEL-1];
    // squished shapes are zero over the second half period
    zero_h    = sd.p[PHASE_W-1];
    gate      = !sd.p[PHASE_W-2];
    p_le_half = ({1'b0, sd.p} <= PH_HALF);

    s_sgn = sd.neg;
    s_mag = smag_q;
    t_sgn = sd.neg;
    t_mag = sd.t;
    case (sd.shape) inside
      SH_SQUI_SINE, SH_SQUI_ABS_SINE, SH_CUBE_SQUI_SINE, SH_CUBE_SQUI_ABS_SINE: begin
        if (zero_h) begin
          s_sgn = 1'b0;
          s_mag = '0;
        end
      end
      SH_SQUI_TRI, SH_ABS_SQUI_TRI, SH_CUBE_SQUI_TRI, SH_ABS_CUBE_SQUI_TRI: begin
        if (zero_h) begin
          t_sgn = 1'b0;
          t_mag = '0;
        end
      end
      default: ;
    endcase

    // saw rises 0..1 up to half period, then -1..0
    if (p_le_half) begin
      w_sgn  = 1'b0;
      w_mag  = MAG_W'(sd.p) << SAW_SH;
      aw_mag = MAG_W'(sd.p) << SAW_SH;
    end else begin
      w_sgn  = 1'b1;
      w_mag  = MAG_W'(PH_N - {1'b0, sd.p}) << SAW_SH;
      aw_mag = MAG_W'({1'b0, sd.p} - PH_HALF) << SAW_SH;
    end

    case (sd.shape) inside
      SH_SINE, SH_SQUI_SINE, SH_CUBE_SINE, SH_CUBE_SQUI_SINE: begin
        sel_sgn = s_sgn;
        sel_mag = s_mag;
      end
      SH_RECT_SINE, SH_CUBE_RECT_SINE: begin
        sel_sgn = 1'b0;
        sel_mag = s_sgn ? '0 : s_mag;
      end
      SH_ABS_SINE, SH_SQUI_ABS_SINE, SH_CUBE_ABS_SINE, SH_CUBE_SQUI_ABS_SINE: begin
        sel_sgn = 1'b0;
        sel_mag = s_mag;
      end
      SH_QUART_SINE, SH_CUBE_QUART_SINE: begin
        sel_sgn = 1'b0;
        sel_mag = gate ? s_mag : '0;
      end
      SH_SQUARE: begin
        sel_sgn = sd.p[PHASE_W-1];
        sel_mag = Q_ONE;
      end
      SH_RECT_SQUARE: begin
        sel_sgn = 1'b0;
        sel_mag = sd.p[PHASE_W-1] ? '0 : Q_ONE;
      end
      SH_SAW, SH_CUBE_SAW: begin
        sel_sgn = w_sgn;
        sel_mag = w_mag;
      end
      SH_RECT_SAW, SH_CUBE_RECT_SAW: begin
        sel_sgn = 1'b0;
        sel_mag = w_sgn ? '0 : w_mag;
      end
      SH_ABS_SAW, SH_CUBE_ABS_SAW: begin
        sel_sgn = 1'b0;
        sel_mag = aw_mag;
      end
      SH_TRI, SH_SQUI_TRI, SH_CUBE_TRI, SH_CUBE_SQUI_TRI: begin
        sel_sgn = t_sgn;
        sel_mag = t_mag;
      end
      SH_RECT_TRI, SH_CUBE_RECT_TRI: begin
        sel_sgn = 1'b0;
        sel_mag = t_sgn ? '0 : t_mag;
      end
      SH_ABS_TRI, SH_ABS_SQUI_TRI, SH_CUBE_ABS_TRI, SH_ABS_CUBE_SQUI_TRI: begin
        // |cube(x)| equals cube(|x|)
        sel_sgn = 1'b0;
        sel_mag = t_mag;
      end
      SH_QUART_TRI, SH_CUBE_QUART_TRI: begin
        sel_sgn = 1'b0;
        sel_mag = gate ? t_mag : '0;
      end
      default: begin
        sel_sgn = s_sgn;
        sel_mag = s_mag;
      end
    endcase

    case (sd.shape) inside
      SH_CUBE_SAW, SH_CUBE_RECT_SAW, SH_CUBE_ABS_SAW, SH_CUBE_SINE, SH_CUBE_RECT_SINE,
      SH_CUBE_ABS_SINE, SH_CUBE_QUART_SINE, SH_CUBE_SQUI_SINE, SH_CUBE_SQUI_ABS_SINE,
      SH_CUBE_TRI, SH_CUBE_RECT_TRI, SH_CUBE_ABS_TRI, SH_CUBE_QUART_TRI,
      SH_CUBE_SQUI_TRI, SH_ABS_CUBE_SQUI_TRI: cube_d = 1'b1;
      default: cube_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sgn_q  <= sel_sgn;
      mag_q  <= sel_mag;
      cube_q <= cube_d;
    end
  end

  // ---------------- stages 10..11: cube on the magnitude ----------------
  logic [PROD_W-1:0] sq_prod, cb_prod;
  logic [MAG_W-1:0]  m2_q, mag2_q, cm_q;
  logic              sgn2_q, cube2_q, sgn3_q;

  assign sq_prod = PROD_W'(mag_q) * PROD_W'(mag_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m2_q    <= sq_prod[Q_FRAC+MAG_W-1:Q_FRAC];
      mag2_q  <= mag_q;
      sgn2_q  <= sgn_q;
      cube2_q <= cube_q;
    end
  end

  assign cb_prod = PROD_W'(m2_q) * PROD_W'(mag2_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cm_q   <= cube2_q ? cb_prod[Q_FRAC+MAG_W-1:Q_FRAC] : mag2_q;
      sgn3_q <= sgn2_q;
    end
  end

  // ---------------- stage 12: scale to full scale, round half up ----------------
  logic [FS_PROD_W-1:0] fs_prod_q;
  logic                 sgn4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fs_prod_q <= FS_PROD_W'(cm_q) * FS_PROD_W'(FULL_SCALE) + ROUND_HALF;
      sgn4_q    <= sgn3_q;
    end
  end

  // ---------------- stage 13: clamp, apply sign, output register ----------------
  logic [FS_PROD_W-Q_FRAC-1:0] rnd;
  logic [SAMPLE_W-1:0]         mag_s;
  logic signed [SAMPLE_W-1:0]  sample_d, sample_q;

  always_comb begin
    rnd   = fs_prod_q[FS_PROD_W-1:Q_FRAC];
    mag_s = (rnd > (FS_PROD_W - Q_FRAC)'(FULL_SCALE)) ? FULL_SCALE : SAMPLE_W'(rnd);
    sample_d = sgn4_q ? -$signed(mag_s) : $signed(mag_s);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sample_q <= sample_d;
    end
  end

  assign sample_o = sample_q;

endmodule

### tb/mswg_sample_checker.sv
// Checker: predicts each sample of the waveform generator and compares it with the DUT output.
`timescale 1ns / 1ps
module mswg_sample_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic                                 cfg_ready_i,
  input  logic [mswg_pkg::SHAPE_W-1:0]         shape_select_i,
  input  logic                                 phase_valid_i,
  input  logic                                 phase_ready_i,
  input  logic [mswg_pkg::PHASE_W-1:0]         phase_i,
  input  logic                                 sample_valid_i,
  input  logic                                 sample_ready_i,
  input  logic signed [mswg_pkg::SAMPLE_W-1:0] sample_i,
  output int                                   mismatch_count,
  output int                                   samples_pending
);
  import mswg_pkg::*;

  localparam int unsigned PH_N     = 1 << PHASE_W;
  localparam int unsigned PH_HALF  = PH_N >> 1;
  localparam int unsigned PH_QUART = PH_N >> 2;
  localparam longint      ONE_Q30  = 64'sd1 << 30;
  localparam bit [63:0]   FS_MAG   = (64'd1 << (SAMPLE_W - 1)) - 64'd1;

  typedef struct {
    shape_e                    shape;
    logic [PHASE_W-1:0]        phase;
    logic signed [SAMPLE_W-1:0] sample;
  } sample_expect_t;

  sample_expect_t expected_samples[$];
  shape_e         shape_reg = SH_SINE;

  function automatic bit [63:0] taylor_coef(int idx);
    case (idx)
      0:       return 64'd3864;
      1:       return 64'd172272;
      2:       return 64'd5026995;
      3:       return 64'd85569306;
      4:       return 64'd693598668;
      default: return 64'd1686629713;
    endcase
  endfunction

  // sin(pi/2 * k/quarter) in Q30, Horner on t^2 with truncating products
  function automatic longint quarter_wave_sine(int unsigned k);
    bit [63:0] t, t2, acc;
    t   = 64'(k) << (32 - PHASE_W);
    t2  = (t * t) >> 30;
    acc = 64'd61;
    for (int i = 0; i < 6; i++) acc = taylor_coef(i) - ((acc * t2) >> 30);
    acc = (t * acc) >> 30;
    if (acc > 64'(ONE_Q30)) acc = 64'(ONE_Q30);
    return longint'(acc);
  endfunction

  function automatic longint sine_of(int unsigned p);
    int unsigned q, k;
    longint      m;
    q = (p >> (PHASE_W - 2)) & 3;
    k = p & (PH_QUART - 1);
    m = q[0] ? quarter_wave_sine(PH_QUART - k) : quarter_wave_sine(k);
    return q[1] ? -m : m;
  endfunction

  function automatic longint triangle_of(int unsigned p);
    int unsigned q, k, j;
    longint      m;
    q = (p >> (PHASE_W - 2)) & 3;
    k = p & (PH_QUART - 1);
    j = q[0] ? (PH_QUART - k) : k;
    m = longint'(64'(j) << (32 - PHASE_W));
    return q[1] ? -m : m;
  endfunction

  function automatic longint saw_of(int unsigned p);
    if (p <= PH_HALF) return longint'(64'(p) << (31 - PHASE_W));
    return -longint'(64'(PH_N - p) << (31 - PHASE_W));
  endfunction

  function automatic longint abs_saw_of(int unsigned p);
    if (p <= PH_HALF) return saw_of(p);
    return longint'(64'(p - PH_HALF) << (31 - PHASE_W));
  endfunction

  function automatic longint mag_of(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint rect_of(longint v);
    return (v > 0) ? v : 0;
  endfunction

  // cube on the magnitude, sign put back
  function automatic longint cube_of(longint v);
    bit [63:0] m, c;
    m = 64'(mag_of(v));
    c = (((m * m) >> 30) * m) >> 30;
    return (v < 0) ? -longint'(c) : longint'(c);
  endfunction

  function automatic longint squished_sine(int unsigned p);
    return (p < PH_HALF) ? sine_of((2 * p) & (PH_N - 1)) : 0;
  endfunction

  function automatic longint squished_triangle(int unsigned p);
    return (p < PH_HALF) ? triangle_of((2 * p) & (PH_N - 1)) : 0;
  endfunction

  function automatic longint shape_level(shape_e s, int unsigned p);
    bit     gate;
    longint qs, qt;
    gate = ((p >> (PHASE_W - 2)) & 1) == 0;   // first and third quarter
    qs   = gate ? mag_of(sine_of(p)) : 0;
    qt   = gate ? mag_of(triangle_of(p)) : 0;
    case (s)
      SH_SINE:               return sine_of(p);
      SH_RECT_SINE:          return rect_of(sine_of(p));
      SH_ABS_SINE:           return mag_of(sine_of(p));
      SH_SQUARE:             return (p >= PH_HALF) ? -ONE_Q30 : ONE_Q30;
      SH_RECT_SQUARE:        return (p >= PH_HALF) ? 0 : ONE_Q30;
      SH_QUART_SINE:         return qs;
      SH_SQUI_SINE:          return squished_sine(p);
      SH_SQUI_ABS_SINE:      return mag_of(squished_sine(p));
      SH_SAW:                return saw_of(p);
      SH_RECT_SAW:           return rect_of(saw_of(p));
      SH_ABS_SAW:            return abs_saw_of(p);
      SH_CUBE_SAW:           return cube_of(saw_of(p));
      SH_CUBE_RECT_SAW:      return cube_of(rect_of(saw_of(p)));
      SH_CUBE_ABS_SAW:       return cube_of(abs_saw_of(p));
      SH_CUBE_SINE:          return cube_of(sine_of(p));
      SH_CUBE_RECT_SINE:     return cube_of(rect_of(sine_of(p)));
      SH_CUBE_ABS_SINE:      return cube_of(mag_of(sine_of(p)));
      SH_CUBE_QUART_SINE:    return cube_of(qs);
      SH_CUBE_SQUI_SINE:     return cube_of(squished_sine(p));
      SH_CUBE_SQUI_ABS_SINE: return cube_of(mag_of(squished_sine(p)));
      SH_TRI:                return triangle_of(p);
      SH_RECT_TRI:           return rect_of(triangle_of(p));
      SH_ABS_TRI:            return mag_of(triangle_of(p));
      SH_QUART_TRI:          return qt;
      SH_SQUI_TRI:           return squished_triangle(p);
      SH_ABS_SQUI_TRI:       return mag_of(squished_triangle(p));
      SH_CUBE_TRI:           return cube_of(triangle_of(p));
      SH_CUBE_RECT_TRI:      return cube_of(rect_of(triangle_of(p)));
      SH_CUBE_ABS_TRI:       return cube_of(mag_of(triangle_of(p)));
      SH_CUBE_QUART_TRI:     return cube_of(qt);
      SH_CUBE_SQUI_TRI:      return cube_of(squished_triangle(p));
      default:               return mag_of(cube_of(squished_triangle(p)));
    endcase
  endfunction

  // Q30 level -> Q1.15 sample, round half up, clamp to full scale
  function automatic logic signed [SAMPLE_W-1:0] predict_sample(shape_e s,
                                                                logic [PHASE_W-1:0] p);
    longint    v;
    bit [63:0] m, r;
    v = shape_level(s, int'(p));
    m = 64'(mag_of(v));
    if (m > 64'(ONE_Q30)) m = 64'(ONE_Q30);
    r = (m * FS_MAG + (64'd1 << 29)) >> 30;
    if (r > FS_MAG) r = FS_MAG;
    if (v < 0) r = 64'd0 - r;
    return r[SAMPLE_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: MISMATCH %s", $time, msg);
    mismatch_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sample_expect_t head;
    if (!rst_ni) begin
      shape_reg = SH_SINE;
      expected_samples.delete();
      samples_pending = 0;
      mismatch_count  = 0;
    end else begin
      if (sample_valid_i && sample_ready_i) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("sample %0d with no phase word outstanding", sample_i));
        end else begin
          head = expected_samples.pop_front();
          if (sample_i !== head.sample)
            report_mismatch($sformatf("shape %s phase %0d: sample %0d, expected %0d",
                                      head.shape.name(), head.phase, sample_i, head.sample));
        end
      end
      if (phase_valid_i && phase_ready_i)
        expected_samples.push_back('{shape_reg, phase_i, predict_sample(shape_reg, phase_i)});
      // new shape applies to phase words taken after this edge
      if (cfg_valid_i && cfg_ready_i) shape_reg = shape_e'(shape_select_i);
      samples_pending = expected_samples.size();
    end
  end

endmodule

### tb/tb_multi_shape_waveform_generator.sv
// Testbench top: clock, reset, phase/config stimulus, sample back-pressure and final verdict.
`timescale 1ns / 1ps
module tb_multi_shape_waveform_generator;
  import mswg_pkg::*;

  // Nothing accepted on any channel for this many cycles means the DUT is hung
  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 850;
  localparam int DRAIN_CYCLES = 20;     // extra wait after the checker queue empties
  localparam int N_DIRECTED   = 24;

  logic                       clk_i          = 1'b0;
  logic                       rst_ni         = 1'b0;
  logic                       cfg_valid_i    = 1'b0;
  logic                       cfg_ready_o;
  logic [SHAPE_W-1:0]         shape_select_i = '0;
  logic                       phase_valid_i  = 1'b0;
  logic                       phase_ready_o;
  logic [PHASE_W-1:0]         phase_i        = '0;
  logic                       sample_valid_o;
  logic                       sample_ready_i = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_o;

  int mismatch_count;
  int samples_pending;

  multi_shape_waveform_generator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .shape_select_i (shape_select_i),
    .phase_valid_i  (phase_valid_i),
    .phase_ready_o  (phase_ready_o),
    .phase_i        (phase_i),
    .sample_valid_o (sample_valid_o),
    .sample_ready_i (sample_ready_i),
    .sample_o       (sample_o)
  );

  mswg_sample_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .shape_select_i  (shape_select_i),
    .phase_valid_i   (phase_valid_i),
    .phase_ready_i   (phase_ready_o),
    .phase_i         (phase_i),
    .sample_valid_i  (sample_valid_o),
    .sample_ready_i  (sample_ready_i),
    .sample_i        (sample_o),
    .mismatch_count  (mismatch_count),
    .samples_pending (samples_pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Sample side back-pressure. Modes last a random number of cycles:
  // always ready, mostly ready, mostly stalled, or a rotating 8-bit mask.
  // ---------------------------------------------------------------------------
  int       stall_mode;
  int       stall_left = 0;
  bit [7:0] stall_mask = 8'hff;

  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
      stall_mask = 8'($urandom_range(1, 255));
    end
    stall_left--;
    stall_mask = {stall_mask[6:0], stall_mask[7]};
    case (stall_mode)
      0:       sample_ready_i <= 1'b1;
      1:       sample_ready_i <= ($urandom_range(0, 3) != 0);
      2:       sample_ready_i <= ($urandom_range(0, 3) == 0);
      default: sample_ready_i <= stall_mask[0];
    endcase
  end

  // ---------------------------------------------------------------------------
  // Watchdog: counts cycles in which no transaction happens on any channel.
  // ---------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (phase_valid_i && phase_ready_o) || (sample_valid_o && sample_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("multi_shape_waveform_generator verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Phase side: bursts of random length, random gaps between them. Valid is
  // left high after a transaction so back-to-back words need no toggle.
  // ---------------------------------------------------------------------------
  int          burst_left = 0;
  shape_e      cur_shape  = SH_SINE;
  int unsigned sweep_pos  = 0;

  task automatic send_phase(input logic [PHASE_W-1:0] p);
    int gap;
    @(negedge clk_i);
    phase_valid_i <= 1'b1;
    phase_i       <= p;
    do @(posedge clk_i); while (!phase_ready_o);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        phase_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  // Shape changes only with the pipeline drained.
  task automatic write_shape(input shape_e s);
    @(negedge clk_i);
    phase_valid_i <= 1'b0;
    while (samples_pending != 0) @(negedge clk_i);
    cfg_valid_i    <= 1'b1;
    shape_select_i <= s;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_shape  = s;
    burst_left = 0;
  endtask

  // Mostly uniform phases, plus quarter-boundary neighbors, slow sweeps and ends
  function automatic logic [PHASE_W-1:0] pick_phase();
    int unsigned quarter;
    case ($urandom_range(0, 9))
      6, 7: begin
        quarter = $urandom_range(0, 3);
        return PHASE_W'((quarter << (PHASE_W - 2)) + $urandom_range(0, 4) - 2);
      end
      8: begin
        sweep_pos += $urandom_range(1, 64);
        return PHASE_W'(sweep_pos);
      end
      9:       return $urandom_range(0, 1) ? '1 : PHASE_W'($urandom_range(0, 3));
      default: return PHASE_W'($urandom);
    endcase
  endfunction

  // Directed points: quadrant edges under the reset shape, square and saw
  // at half period, absolute saw past the midpoint, quarter-gate and squish
  // boundaries, and the last shape code.
  shape_e dir_shape [N_DIRECTED] = '{
    SH_SINE, SH_SINE, SH_SINE, SH_SINE, SH_SINE, SH_SINE, SH_SINE,
    SH_SQUARE, SH_SQUARE,
    SH_SAW, SH_SAW, SH_SAW,
    SH_ABS_SAW, SH_ABS_SAW,
    SH_QUART_SINE, SH_QUART_SINE, SH_QUART_SINE, SH_QUART_SINE,
    SH_SQUI_SINE, SH_SQUI_SINE, SH_SQUI_SINE,
    SH_ABS_CUBE_SQUI_TRI, SH_ABS_CUBE_SQUI_TRI, SH_ABS_CUBE_SQUI_TRI
  };
  logic [PHASE_W-1:0] dir_phase [N_DIRECTED] = '{
    12'd0, 12'd1024, 12'd2048, 12'd3072, 12'd4095, 12'haaa, 12'h555,
    12'd2047, 12'd2048,
    12'd2048, 12'd2049, 12'd0,
    12'd2049, 12'd4095,
    12'd1023, 12'd1024, 12'd3071, 12'd3072,
    12'd2047, 12'd2048, 12'd1024,
    12'd511, 12'd2048, 12'd1536
  };

  initial begin
    int     random_sent;
    int     round_no;
    int     n_words;
    shape_e next_shape;

    random_sent = 0;
    round_no    = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // first directed words run on the reset shape without any write
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (dir_shape[i] != cur_shape) write_shape(dir_shape[i]);
      send_phase(dir_phase[i]);
    end

    // random rounds: a shape write, then a run of phase words
    while (random_sent < RANDOM_ITEMS) begin
      if (round_no < 32) begin
        next_shape = shape_e'((round_no * 13 + 31) % 32);   // visits every code once
      end else begin
        next_shape = shape_e'($urandom_range(0, 31));
      end
      write_shape(next_shape);
      n_words = $urandom_range(8, 40);
      repeat (n_words) send_phase(pick_phase());
      random_sent += n_words;
      round_no++;
    end

    @(negedge clk_i);
    phase_valid_i <= 1'b0;
    while (samples_pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && samples_pending == 0) begin
      $display("multi_shape_waveform_generator verification clean");
    end else begin
      $display("multi_shape_waveform_generator verification failed");
    end
    $finish;
  end

endmodule

### multi_shape_waveform_generator.f
src/mswg_pkg.sv
src/multi_shape_waveform_generator.sv
tb/mswg_sample_checker.sv
tb/tb_multi_shape_waveform_generator.sv
